// ===== rtl/core/hcol_pkg.sv =====
// ----------------------------------------------------------------------------
// hcol_pkg: shared types and constants for the hit-count ordered list
// Transaction payloads, status and kind codes, cell control and cell status.
// ----------------------------------------------------------------------------
package hcol_pkg;

   localparam int HANDLE_W       = 16;
   localparam int COUNT_W        = 32;
   localparam int POS_W          = 6;
   localparam int TOTAL_W        = 7;
   localparam int STATUS_W       = 2;
   localparam int DEF_LIST_DEPTH = 64;

   localparam logic KIND_INSERT  = 1'b0;
   localparam logic KIND_PROMOTE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd2;

   typedef struct packed {
      logic                kind;
      logic [HANDLE_W-1:0] entry_handle;
      logic [COUNT_W-1:0]  hit_count;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0]    position;
      logic [TOTAL_W-1:0]  entry_total;
      logic [HANDLE_W-1:0] head_handle;
      logic [HANDLE_W-1:0] tail_handle;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // command broadcast to every cell; only the cell under the cursor acts
   typedef struct packed {
      logic shift;   // take the upper neighbor's entry
      logic load;    // take the key entry
   } cell_cmd_type;

   // per-cell report, zero unless the cursor points at or just below the cell
   typedef struct packed {
      logic                hit;        // cell under the cursor holds the key handle
      logic                up_lt;      // cell above the cursor has count below the key
      logic [HANDLE_W-1:0] up_handle;  // handle of the cell above the cursor
   } cell_stat_type;

endpackage

// ===== rtl/core/hcol_cell.sv =====
// ----------------------------------------------------------------------------
// hcol_cell: one slot of the ordered list
// Holds a handle and a count, takes its upper neighbor's entry or the key.
// ----------------------------------------------------------------------------
module hcol_cell
   import hcol_pkg::*;
#(
   parameter int IDX_W      = 6,
   parameter int CELL_INDEX = 0
) (
   input  logic                clock,
   input  logic [IDX_W-1:0]    idx,
   input  cell_cmd_type        cmd,
   input  logic [HANDLE_W-1:0] key_handle,
   input  logic [COUNT_W-1:0]  key_count,
   input  logic [HANDLE_W-1:0] prev_handle,
   input  logic [COUNT_W-1:0]  prev_count,
   output logic [HANDLE_W-1:0] handle,
   output logic [COUNT_W-1:0]  count,
   output cell_stat_type       stat
);

   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                at_cursor;
   logic                above_cursor;

   assign at_cursor    = (idx == IDX_W'(CELL_INDEX));
   assign above_cursor = ({1'b0, idx} == (IDX_W+1)'(CELL_INDEX + 1));

   always_comb begin
      handle_in = handle_ff;
      count_in  = count_ff;
      if (at_cursor && cmd.shift) begin
         handle_in = prev_handle;
         count_in  = prev_count;
      end else if (at_cursor && cmd.load) begin
         handle_in = key_handle;
         count_in  = key_count;
      end
   end

   always_ff @(posedge clock) begin
      handle_ff <= handle_in;
      count_ff  <= count_in;
   end

   assign handle         = handle_ff;
   assign count          = count_ff;
   assign stat.hit       = at_cursor && (handle_ff == key_handle);
   assign stat.up_lt     = above_cursor && (count_ff < key_count);
   assign stat.up_handle = above_cursor ? handle_ff : '0;

endmodule

// ===== rtl/core/hit_count_ordered_list.sv =====
// ----------------------------------------------------------------------------
// hit_count_ordered_list: entry list kept in descending hit-count order
// Insert and promote by walking a cursor along a row of slot cells.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-----------------------------------
//  req     | in  | req_valid/req_ready | kind, entry_handle, hit_count
//  rsp     | out | rsp_valid/rsp_ready | position, entry_total, head/tail, status
//
//  One transaction at a time. An insert opens a hole just past the last
//  entry and climbs it past strictly lower counts. A promote first searches
//  from the head for the handle, then climbs the same way.
//  The cursor moves one slot per cycle through the cells.
//  A full table answers without a climb, an unknown handle after the search.
//  Reset clears the entry count and control; slot contents are not cleared.
//  The result register lets the next request be taken while a result waits;
//  a finished transaction holds in the response state while rsp is stalled.
//
module hit_count_ordered_list
   import hcol_pkg::*;
#(
   parameter int LIST_DEPTH = DEF_LIST_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IDX_W = $clog2(LIST_DEPTH);
   localparam int OCC_W = $clog2(LIST_DEPTH + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_FIND = 2'd1;
   localparam logic [1:0] ST_MOVE = 2'd2;
   localparam logic [1:0] ST_RESP = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;       // cursor: search slot or hole
   logic [OCC_W-1:0]    occ_ff, occ_in;
   logic                kind_ff, kind_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [HANDLE_W-1:0] tail_ff, tail_in;
   logic [IDX_W-1:0]    pos_ff, pos_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   cell_cmd_type        cmd;
   logic [HANDLE_W-1:0] cell_handle [LIST_DEPTH];
   logic [COUNT_W-1:0]  cell_count  [LIST_DEPTH];
   cell_stat_type       cell_stat   [LIST_DEPTH];

   logic                sel_hit;
   logic                sel_lt;
   logic [HANDLE_W-1:0] sel_up_handle;
   logic [OCC_W-1:0]    idx_ext;
   logic [OCC_W-1:0]    tail_slot;
   logic                req_take;
   logic                rsp_load;

   // ---- row of slot cells, each fed by the one above it ----
   for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
      logic [HANDLE_W-1:0] up_handle;
      logic [COUNT_W-1:0]  up_count;
      if (g == 0) begin : g_top
         assign up_handle = '0;
         assign up_count  = '0;
      end else begin : g_mid
         assign up_handle = cell_handle[g-1];
         assign up_count  = cell_count[g-1];
      end
      hcol_cell #(
         .IDX_W      (IDX_W),
         .CELL_INDEX (g)
      ) u_cell (
         .clock       (clock),
         .idx         (idx_ff),
         .cmd         (cmd),
         .key_handle  (handle_ff),
         .key_count   (count_ff),
         .prev_handle (up_handle),
         .prev_count  (up_count),
         .handle      (cell_handle[g]),
         .count       (cell_count[g]),
         .stat        (cell_stat[g])
      );
   end

   // only the cells next to the cursor report, so an OR picks them out
   always_comb begin
      sel_hit       = 1'b0;
      sel_lt        = 1'b0;
      sel_up_handle = '0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         sel_hit       = sel_hit | cell_stat[i].hit;
         sel_lt        = sel_lt | cell_stat[i].up_lt;
         sel_up_handle = sel_up_handle | cell_stat[i].up_handle;
      end
   end

   assign idx_ext   = OCC_W'(idx_ff);
   // slot that is last once the hole is filled
   assign tail_slot = (kind_ff == KIND_INSERT) ? occ_ff : occ_ff - OCC_W'(1);
   assign req_take  = req_valid && req_ready;
   assign rsp_load  = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ready);

   // ---- sequencer ----
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      occ_in    = occ_ff;
      kind_in   = kind_ff;
      handle_in = handle_ff;
      count_in  = count_ff;
      tail_in   = tail_ff;
      pos_in    = pos_ff;
      status_in = status_ff;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               kind_in   = req_data.kind;
               handle_in = req_data.entry_handle;
               count_in  = req_data.hit_count;
               pos_in    = '0;
               status_in = STATUS_OK;
               if (req_data.kind == KIND_INSERT) begin
                  if (occ_ff == OCC_W'(LIST_DEPTH)) begin
                     status_in = STATUS_FULL;
                     state_in  = ST_RESP;
                  end else begin
                     // hole opens just past the last entry
                     idx_in   = IDX_W'(occ_ff);
                     state_in = ST_MOVE;
                  end
               end else begin
                  if (occ_ff == '0) begin
                     status_in = STATUS_MISS;
                     state_in  = ST_RESP;
                  end else begin
                     idx_in   = '0;
                     state_in = ST_FIND;
                  end
               end
            end
         end
         ST_FIND: begin
            // search from the head so the nearest duplicate wins
            if (sel_hit) begin
               state_in = ST_MOVE;
            end else if (idx_ext == occ_ff - OCC_W'(1)) begin
               status_in = STATUS_MISS;
               state_in  = ST_RESP;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_MOVE: begin
            if (sel_lt) begin
               // entry above has a strictly lower count: pull it down
               cmd.shift = 1'b1;
               idx_in    = idx_ff - IDX_W'(1);
               if (idx_ext == tail_slot) begin
                  tail_in = sel_up_handle;
               end
            end else begin
               cmd.load = 1'b1;
               pos_in   = idx_ff;
               state_in = ST_RESP;
               if (kind_ff == KIND_INSERT) begin
                  occ_in = occ_ff + OCC_W'(1);
                  if (idx_ext == occ_ff) begin
                     tail_in = handle_ff;
                  end
               end
            end
         end
         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---- result register ----
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.position    = POS_W'(pos_ff);
         rsp_data_in.entry_total = TOTAL_W'(occ_ff);
         rsp_data_in.head_handle = (occ_ff != '0) ? cell_handle[0] : '0;
         rsp_data_in.tail_handle = (occ_ff != '0) ? tail_ff : '0;
         rsp_data_in.status      = status_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      kind_ff     <= kind_in;
      handle_ff   <= handle_in;
      count_ff    <= count_in;
      tail_ff     <= tail_in;
      pos_ff      <= pos_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---- assertions ----
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(LIST_DEPTH))
      else $error("entry count beyond list depth");

   a_find_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIND) |-> (idx_ext < occ_ff))
      else $error("search cursor past last entry");

   a_move_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOVE) |-> (idx_ext <= occ_ff) && (idx_ext < OCC_W'(LIST_DEPTH)))
      else $error("hole outside the list");

   a_take_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff != ST_IDLE))
      else $error("accepted transaction not started");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_load && (status_ff == STATUS_FULL) |-> (occ_ff == OCC_W'(LIST_DEPTH)))
      else $error("full reported on a table with room");

endmodule

// ===== tb/sv/hit_count_ordered_list_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hit_count_ordered_list_tb: self-checking bench for the hit-count ordered list
// A short table of directed transactions is followed by random inserts and
// promotes. A behavioral table copy predicts each response not typed in.
// ----------------------------------------------------------------------------
module hit_count_ordered_list_tb;
   import hcol_pkg::*;

   localparam int DEPTH        = DEF_LIST_DEPTH;
   localparam int RANDOM_OPS   = 400;
   localparam int QUIET_OPS    = 50;            // tail of the run with no idling
   localparam int HOLD_AT      = 150;           // transactions sent before the long stall
   localparam int HOLD_CYCLES  = 300;           // well over one worst-case operation
   localparam int DRAIN_CYCLES = 2 * DEPTH + 8; // worst-case latency plus margin

   // one row of the directed table; answer is used only when typed is set
   typedef struct {
      req_type op;
      bit      typed;
      rsp_type answer;
   } dir_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // behavioral copy of the sorted table, slot 0 holds the highest count
   logic [HANDLE_W-1:0] list_handle [DEPTH];
   logic [COUNT_W-1:0]  list_count  [DEPTH];
   int unsigned         list_size;

   rsp_type     answers_due [$];   // predicted responses, oldest first
   int unsigned mismatch_total;
   int unsigned sent_total;
   bit          quiet;             // set near the end: no idling on either side

   hit_count_ordered_list #(
      .LIST_DEPTH (DEPTH)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // --------------------------------------------------------------------------
   // Predictor. Applies one transaction to the table copy and returns the
   // response the block must give for it.
   // --------------------------------------------------------------------------
   function automatic rsp_type apply_list_op(input req_type op);
      rsp_type             r;
      int unsigned         slot;
      int unsigned         i;
      bit                  found;
      logic [HANDLE_W-1:0] moving;
      r      = '0;
      slot   = 0;
      found  = 1'b0;
      r.status = STATUS_OK;
      if (op.kind == KIND_INSERT) begin
         if (list_size >= DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            // new entry goes just below the lowest entry with count >= its own
            for (i = list_size; i > 0; i--) begin
               if (!found && list_count[i-1] >= op.hit_count) begin
                  slot  = i;
                  found = 1'b1;
               end
            end
            for (i = list_size; i > slot; i--) begin
               list_handle[i] = list_handle[i-1];
               list_count[i]  = list_count[i-1];
            end
            list_handle[slot] = op.entry_handle;
            list_count[slot]  = op.hit_count;
            list_size++;
         end
      end else begin
         // duplicates: the copy nearest the head is the one promoted
         for (i = 0; i < list_size; i++) begin
            if (!found && list_handle[i] == op.entry_handle) begin
               slot  = i;
               found = 1'b1;
            end
         end
         if (found) begin
            // climbs past strictly lower counts only, never moves down
            moving = list_handle[slot];
            while (slot > 0 && list_count[slot-1] < op.hit_count) begin
               list_handle[slot] = list_handle[slot-1];
               list_count[slot]  = list_count[slot-1];
               slot--;
            end
            list_handle[slot] = moving;
            list_count[slot]  = op.hit_count;
         end else begin
            r.status = STATUS_MISS;
            slot     = 0;
         end
      end
      r.position    = POS_W'(slot);
      r.entry_total = TOTAL_W'(list_size);
      r.head_handle = (list_size > 0) ? list_handle[0] : '0;
      r.tail_handle = (list_size > 0) ? list_handle[list_size-1] : '0;
      return r;
   endfunction

   function automatic dir_row_type make_row(input logic kind,
                                            input logic [HANDLE_W-1:0] handle,
                                            input logic [COUNT_W-1:0] count);
      dir_row_type row;
      row.op.kind         = kind;
      row.op.entry_handle = handle;
      row.op.hit_count    = count;
      row.typed           = 1'b0;
      row.answer          = '0;
      return row;
   endfunction

   function automatic dir_row_type make_typed_row(input logic kind,
                                                  input logic [HANDLE_W-1:0] handle,
                                                  input logic [COUNT_W-1:0] count,
                                                  input logic [POS_W-1:0] pos,
                                                  input logic [TOTAL_W-1:0] total,
                                                  input logic [HANDLE_W-1:0] head,
                                                  input logic [HANDLE_W-1:0] tail,
                                                  input logic [STATUS_W-1:0] status);
      dir_row_type row;
      row                    = make_row(kind, handle, count);
      row.typed              = 1'b1;
      row.answer.position    = pos;
      row.answer.entry_total = total;
      row.answer.head_handle = head;
      row.answer.tail_handle = tail;
      row.answer.status      = status;
      return row;
   endfunction

   // --------------------------------------------------------------------------
   // Request side. Drives one transaction at a falling edge, optionally after
   // a short idle burst, and holds it until the block takes it. The expected
   // response is queued at the accepting edge.
   // --------------------------------------------------------------------------
   task automatic send_op(input req_type op, input bit typed, input rsp_type answer);
      rsp_type predicted;
      int      gap;
      gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= op;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // state is updated even where the row carries its own answer
      predicted = apply_list_op(op);
      answers_due.push_back(typed ? answer : predicted);
      sent_total++;
   endtask

   initial begin : stimulus
      dir_row_type script [$];
      req_type     op;
      rsp_type     unused;
      int          n;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      mismatch_total = 0;
      sent_total     = 0;
      list_size      = 0;
      quiet          = 1'b0;
      unused         = '0;

      // directed table; answers typed in only where obvious
      // promote on an empty table: unknown handle, head and tail read as zero
      script.push_back(make_typed_row(KIND_PROMOTE, 16'h0001, 32'd7,
                                      6'd0, 7'd0, 16'h0000, 16'h0000, STATUS_MISS));
      // extremes of handle and count
      script.push_back(make_typed_row(KIND_INSERT, 16'hFFFF, 32'hFFFF_FFFF,
                                      6'd0, 7'd1, 16'hFFFF, 16'hFFFF, STATUS_OK));
      script.push_back(make_typed_row(KIND_INSERT, 16'h0000, 32'h0000_0000,
                                      6'd1, 7'd2, 16'hFFFF, 16'h0000, STATUS_OK));
      // ties at the bottom and at the top keep arrival order
      script.push_back(make_row(KIND_INSERT,  16'h5A5A, 32'h0000_0000));
      script.push_back(make_row(KIND_INSERT,  16'hA5A5, 32'hFFFF_FFFF));
      // duplicate handle, then promote acts on the copy nearest the head
      script.push_back(make_row(KIND_INSERT,  16'h0000, 32'd100));
      script.push_back(make_row(KIND_PROMOTE, 16'h0000, 32'hFFFF_FFFF));
      // lowered count stays in place
      script.push_back(make_row(KIND_PROMOTE, 16'h0000, 32'd0));
      script.push_back(make_row(KIND_INSERT,  16'h1111, 32'd50));
      script.push_back(make_row(KIND_PROMOTE, 16'h5A5A, 32'h8000_0000));
      script.push_back(make_row(KIND_PROMOTE, 16'hBEEF, 32'd3));
      script.push_back(make_row(KIND_PROMOTE, 16'hFFFF, 32'd0));
      script.push_back(make_row(KIND_INSERT,  16'h2222, 32'd1));
      script.push_back(make_row(KIND_PROMOTE, 16'h2222, 32'hFFFF_FFFF));
      script.push_back(make_row(KIND_INSERT,  16'h8000, 32'h7FFF_FFFF));
      script.push_back(make_row(KIND_PROMOTE, 16'h8000, 32'h7FFF_FFFF));
      script.push_back(make_row(KIND_PROMOTE, 16'h0001, 32'd1));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         send_op(script[i].op, script[i].typed, script[i].answer);
      end

      // random part: inserts until the table fills (full is reached here),
      // then mostly promotes with some rejected inserts
      for (n = 0; n < RANDOM_OPS; n++) begin
         if (n >= RANDOM_OPS - QUIET_OPS) quiet = 1'b1;
         if (list_size < DEPTH)
            op.kind = ($urandom_range(0, 99) < 55) ? KIND_INSERT : KIND_PROMOTE;
         else
            op.kind = ($urandom_range(0, 99) < 15) ? KIND_INSERT : KIND_PROMOTE;

         if (list_size > 0 && $urandom_range(0, 99) < (op.kind == KIND_PROMOTE ? 85 : 20))
            op.entry_handle = list_handle[$urandom_range(0, list_size - 1)];
         else
            op.entry_handle = HANDLE_W'($urandom);

         // small counts make ties, copied counts hit the equal-key boundary
         case ($urandom_range(0, 9))
            0:       op.hit_count = '0;
            1:       op.hit_count = '1;
            2, 3, 4: op.hit_count = $urandom_range(0, 15);
            5:       op.hit_count = (list_size > 0) ?
                                    list_count[$urandom_range(0, list_size - 1)] : 32'd7;
            default: op.hit_count = $urandom;
         endcase
         send_op(op, 1'b0, unused);
      end

      @(negedge clock);
      req_valid <= 1'b0;

      while (answers_due.size() != 0) @(posedge clock);
      // give a stray late response time to show up
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_total == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // --------------------------------------------------------------------------
   // Response side. Random stall bursts, one long hold-off so the block
   // fills and back-pressures the request channel, and no stalls once the
   // quiet tail begins.
   // --------------------------------------------------------------------------
   initial begin : response_side
      bit hold_done;
      hold_done = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && sent_total >= HOLD_AT) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 2)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatch_total++;
         $display("%0t ns: %s expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // compare each accepted response against the oldest prediction
   always @(posedge clock) begin : response_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (answers_due.size() == 0) begin
            mismatch_total++;
            $display("%0t ns: response with no transaction outstanding, actual %h",
                     $time, rsp_data);
         end else begin
            want = answers_due.pop_front();
            check_field("position",    32'(want.position),    32'(rsp_data.position));
            check_field("entry_total", 32'(want.entry_total), 32'(rsp_data.entry_total));
            check_field("head_handle", 32'(want.head_handle), 32'(rsp_data.head_handle));
            check_field("tail_handle", 32'(want.tail_handle), 32'(rsp_data.tail_handle));
            check_field("status",      32'(want.status),      32'(rsp_data.status));
         end
      end
   end

   // hard stop, several times the slowest legal run
   initial begin : watchdog
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
